// File: hdl/kd_block_edge_binning_core_assert.svh
// Assertion macros for the kd edge binning core.
// Included by the top level; depends on nothing else.
`ifndef KD_BLOCK_EDGE_BINNING_CORE_ASSERT_SVH
`define KD_BLOCK_EDGE_BINNING_CORE_ASSERT_SVH

`define KD_ASSERT_IMPL(label, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("kd assertion failed");

`define KD_ASSERT_NEXT(label, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("kd assertion failed");

`endif

// File: hdl/kdbin_pkg.sv
// Shared types and constants for the kd edge binning core.
// No dependencies.
package kdbin_pkg;
  localparam int CfgCount = 5;
  localparam logic [2:0] REG_MIN_X = 3'd0;
  localparam logic [2:0] REG_MIN_Y = 3'd1;
  localparam logic [2:0] REG_MAX_X = 3'd2;
  localparam logic [2:0] REG_MAX_Y = 3'd3;
  localparam logic [2:0] REG_LEAF  = 3'd4;

  localparam logic [1:0] STOP_LEAF  = 2'd0;
  localparam logic [1:0] STOP_CROSS = 2'd1;
  localparam logic [1:0] STOP_DEPTH = 2'd2;

  typedef struct packed {
    logic signed [16:0] x0;
    logic signed [16:0] y0;
    logic signed [16:0] x1;
    logic signed [16:0] y1;
  } box_t;

  typedef struct packed {
    logic signed [31:0] sx;
    logic signed [31:0] sy;
    logic signed [31:0] ex;
    logic signed [31:0] ey;
  } edge_t;
endpackage

// File: hdl/kd_block_edge_binning_core.sv
// Top level of the kd edge binning core: APB registers, cell chain, counter RAM.
// Depends on kdbin_pkg, kdbin_cell and kd_block_edge_binning_core_assert.svh.
// Usage:
//   Input channel (in_valid/in_ready) takes one edge; the output channel
//   (out_valid/out_ready) returns its landing node, depth, stop reason and
//   the landing node's counts after the update.
//   The edge descends a chain of MAX_DEPTH+1 cells, one level per counter
//   update; every visited node's counter gets a read-modify-write (S_READ,
//   then S_WRITE) on the counter RAM, and the result is posted from S_DONE
//   after the last level; in_ready rises again together with out_valid;
//   one edge is in flight at a time.
//   After reset a clearing pass zeroes every counter RAM entry; in_ready
//   stays low meanwhile. Configuration writes are taken anytime.
//   A finished result waits in the output register while out_ready is low;
//   the next edge is accepted but holds before its first level until the
//   result is taken.
//   Counters saturate at 2^COUNT_BITS-1.
module kd_block_edge_binning_core #(
  parameter int MAX_DEPTH  = 12,
  parameter int COUNT_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] start_x,
  input  logic signed [31:0] start_y,
  input  logic signed [31:0] end_x,
  input  logic signed [31:0] end_y,
  input  logic               is_real,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [12:0]        node_index,
  output logic [3:0]         landing_depth,
  output logic [1:0]         stop_reason,
  output logic [15:0]        real_total,
  output logic [15:0]        mini_total
);
  import kdbin_pkg::*;

  localparam int IDX_BITS = MAX_DEPTH + 1;
  localparam int LVLS = MAX_DEPTH + 1;
  localparam int DBITS = $clog2(LVLS + 1);

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001, S_IDLE = 5'b00010, S_READ = 5'b00100,
    S_WRITE = 5'b01000, S_DONE = 5'b10000
  } state_t;

  state_t state;
  logic [15:0] r_min_x, r_min_y, r_max_x, r_max_y, r_leaf;
  logic [IDX_BITS:0] clr_addr;
  edge_t edg;
  logic real_flag, edge_held;

  logic [2:0] reg_idx;
  assign reg_idx = paddr[4:2];
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      r_min_x <= 16'h8000; r_min_y <= 16'h8000;
      r_max_x <= 16'h7fff; r_max_y <= 16'h7fff; r_leaf <= 16'd256;
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        REG_MIN_X: r_min_x <= pwdata[15:0];
        REG_MIN_Y: r_min_y <= pwdata[15:0];
        REG_MAX_X: r_max_x <= pwdata[15:0];
        REG_MAX_Y: r_max_y <= pwdata[15:0];
        REG_LEAF:  r_leaf  <= pwdata[15:0];
        default: ;
      endcase
    end
  end
  always_comb begin
    case (reg_idx)
      REG_MIN_X: prdata = {{16{r_min_x[15]}}, r_min_x};
      REG_MIN_Y: prdata = {{16{r_min_y[15]}}, r_min_y};
      REG_MAX_X: prdata = {{16{r_max_x[15]}}, r_max_x};
      REG_MAX_Y: prdata = {{16{r_max_y[15]}}, r_max_y};
      REG_LEAF:  prdata = {16'd0, r_leaf};
      default:   prdata = 32'd0;
    endcase
  end

  // cell chain
  logic [LVLS:0]      go;
  box_t               box [LVLS+1];
  logic [IDX_BITS-1:0] node [LVLS+1];
  logic [LVLS-1:0]    cdone;
  logic [1:0]         creason [LVLS];
  logic               launch, step;

  assign launch = (state == S_IDLE) && edge_held && !out_valid;
  assign go[0] = launch;
  assign box[0] = '{x0: 17'(signed'(r_min_x)), y0: 17'(signed'(r_min_y)),
                    x1: 17'(signed'(r_max_x)), y1: 17'(signed'(r_max_y))};
  assign node[0] = IDX_BITS'(1);

  // the chain advances only when a level's counter update is done
  logic [LVLS:0] go_q;
  box_t box_q [LVLS+1];
  logic [IDX_BITS-1:0] node_q [LVLS+1];

  genvar gi;
  generate
    for (gi = 0; gi < LVLS; gi++) begin : g_cell
      logic       cgo;
      box_t       cbox;
      logic [IDX_BITS-1:0] cnode;
      assign cgo = (gi == 0) ? go[0] : (go_q[gi] && step);
      kdbin_cell #(.IDX_BITS(IDX_BITS)) u_cell (
        .clk(clk), .rst(rst), .in_go(cgo),
        .in_box((gi == 0) ? box[0] : box_q[gi]), .in_edge(edg),
        .in_node((gi == 0) ? node[0] : node_q[gi]), .leaf_size(r_leaf),
        .last_level(gi == LVLS - 1), .out_go(go[gi+1]), .out_box(box[gi+1]),
        .out_node(node[gi+1]), .done(cdone[gi]), .reason(creason[gi]));
    end
  endgenerate

  // hold each cell's handoff until the counter write for its node is made
  always_ff @(posedge clk) begin
    if (rst) go_q <= '0;
    else begin
      for (int i = 1; i <= LVLS; i++) begin
        if (go[i]) go_q[i] <= 1'b1;
        else if (step) go_q[i] <= 1'b0;
      end
      go_q[0] <= 1'b0;
    end
    for (int i = 1; i <= LVLS; i++) begin
      if (go[i]) begin
        box_q[i] <= box[i];
        node_q[i] <= node[i];
      end
    end
    box_q[0] <= box[0];
    node_q[0] <= node[0];
  end

  // level sequencing: current node, whether it stops, and why
  logic [IDX_BITS-1:0] cur_node;
  logic [DBITS-1:0]    cur_depth;
  logic                cur_stop;
  logic [1:0]          cur_reason;
  logic [2*COUNT_BITS-1:0] mem [2**IDX_BITS];
  logic [2*COUNT_BITS-1:0] rd_data, wr_data;
  logic [2*COUNT_BITS-1:0] wr_data_q;
  logic [COUNT_BITS-1:0] rc, mc;
  logic [COUNT_BITS-1:0] cmax;
  assign cmax = '1;

  always_comb begin
    rc = rd_data[2*COUNT_BITS-1:COUNT_BITS];
    mc = rd_data[COUNT_BITS-1:0];
    if (real_flag) begin
      if (rc != cmax) rc = rc + 1'b1;
    end else begin
      if (mc != cmax) mc = mc + 1'b1;
    end
    wr_data = {rc, mc};
  end

  assign step = (state == S_WRITE) && !cur_stop;
  assign in_ready = (state == S_IDLE) && !edge_held;

  always_ff @(posedge clk) begin
    if (state == S_CLEAR) mem[clr_addr[IDX_BITS-1:0]] <= '0;
    else if (state == S_WRITE) mem[cur_node] <= wr_data;
    rd_data <= mem[(state == S_IDLE) ? IDX_BITS'(1) : cur_node];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr_addr <= '0;
      edge_held <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) edge_held <= 1'b1;
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr[IDX_BITS]) state <= S_IDLE;
        end
        S_IDLE: if (launch) begin
          edge_held <= 1'b0;
          state <= S_READ;
        end
        S_READ: state <= S_WRITE;
        S_WRITE: state <= cur_stop ? S_DONE : S_READ;
        S_DONE: begin
          out_valid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      edg <= '{sx: start_x, sy: start_y, ex: end_x, ey: end_y};
      real_flag <= is_real;
    end
    if (launch) begin
      cur_node <= IDX_BITS'(1);
      cur_depth <= '0;
    end else if (step) begin
      cur_node <= node_q[int'(cur_depth) + 1];
      cur_depth <= cur_depth + 1'b1;
    end
    if (S_DONE == state) begin
      node_index <= 13'(cur_node);
      landing_depth <= 4'(cur_depth);
      stop_reason <= cur_reason;
      real_total <= 16'(wr_data_q[2*COUNT_BITS-1:COUNT_BITS]);
      mini_total <= 16'(wr_data_q[COUNT_BITS-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_WRITE) wr_data_q <= wr_data;
  end

  // stop flags from the cell holding the current level
  logic [LVLS-1:0] stop_flag;
  logic [1:0]      stop_rsn [LVLS];
  always_ff @(posedge clk) begin
    for (int i = 0; i < LVLS; i++) begin
      if (rst) stop_flag[i] <= 1'b0;
      else if (cdone[i]) stop_flag[i] <= 1'b1;
      else if (launch) stop_flag[i] <= 1'b0;
      if (cdone[i]) stop_rsn[i] <= creason[i];
    end
  end
  always_comb begin
    cur_stop = stop_flag[cur_depth[DBITS-1:0] < DBITS'(LVLS) ? cur_depth : '0];
    cur_reason = stop_rsn[cur_depth < DBITS'(LVLS) ? cur_depth : '0];
  end

  `include "kd_block_edge_binning_core_assert.svh"
  `KD_ASSERT_IMPL(a_clear_no_accept, state == S_CLEAR, !in_ready)
  `KD_ASSERT_NEXT(a_done_valid, state == S_DONE, out_valid)
  `KD_ASSERT_IMPL(a_depth_bound, state == S_WRITE, cur_depth <= DBITS'(MAX_DEPTH))
endmodule

// File: hdl/kdbin_cell.sv
// One level of the kd descent: split the box it receives and hand the child on.
// Depends on kdbin_pkg.
module kdbin_cell #(
  parameter int IDX_BITS = 13
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_go,
  input  kdbin_pkg::box_t       in_box,
  input  kdbin_pkg::edge_t      in_edge,
  input  logic [IDX_BITS-1:0]   in_node,
  input  logic [15:0]           leaf_size,
  input  logic                  last_level,
  output logic                  out_go,
  output kdbin_pkg::box_t       out_box,
  output logic [IDX_BITS-1:0]   out_node,
  output logic                  done,
  output logic [1:0]            reason
);
  import kdbin_pkg::*;

  logic signed [17:0] w, h;
  logic signed [17:0] mid_sum;
  logic signed [16:0] mid;
  logic signed [31:0] pa, pb;
  logic signed [48:0] thr;
  logic along_x, is_leaf, p1, p2;
  box_t child;

  always_comb begin
    w = 18'(in_box.x1) - 18'(in_box.x0);
    h = 18'(in_box.y1) - 18'(in_box.y0);
    is_leaf = (w <= $signed({2'b00, leaf_size})) && (h <= $signed({2'b00, leaf_size}));
    along_x = (w >= h);
    mid_sum = along_x ? 18'(in_box.x0) + 18'(in_box.x1) : 18'(in_box.y0) + 18'(in_box.y1);
    mid = 17'((mid_sum + ((mid_sum < 0) ? 18'sd1 : 18'sd0)) >>> 1);
    pa = along_x ? in_edge.sx : in_edge.sy;
    pb = along_x ? in_edge.ex : in_edge.ey;
    thr = {{16{mid[16]}}, mid, 16'd0};
    p1 = 49'(pa) >= thr;
    p2 = 49'(pb) >= thr;
    child = in_box;
    if (along_x) begin
      if (p1) child.x0 = mid; else child.x1 = mid;
    end else begin
      if (p1) child.y0 = mid; else child.y1 = mid;
    end
  end

  always_comb begin
    done = in_go;
    if (is_leaf) reason = STOP_LEAF;
    else if (p1 != p2) reason = STOP_CROSS;
    else if (last_level) reason = STOP_DEPTH;
    else begin
      reason = STOP_LEAF;
      done = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_go <= 1'b0;
    end else begin
      out_go <= in_go && !done;
    end
    out_box <= child;
    out_node <= IDX_BITS'({in_node, p1});
  end
endmodule

// File: tb/sv/tb_kd_block_edge_binning_core.sv
// Self-checking testbench for kd_block_edge_binning_core: directed table, then random
// edges per root box setting, checked against an in-bench binning predictor.
// Depends on kdbin_pkg and the core RTL.
module tb_kd_block_edge_binning_core;
  timeunit 1ns;
  timeprecision 1ps;
  import kdbin_pkg::*;

  localparam int DEPTH_LIMIT = 12;
  localparam int SLOTS = 8192;
  localparam int unsigned COUNT_TOP = 65535;

  typedef struct {
    logic [12:0] node;
    logic [3:0]  depth;
    logic [1:0]  reason;
    logic [15:0] real_cnt;
    logic [15:0] mini_cnt;
  } landing_t;

  typedef struct {
    logic [31:0] sx, sy, ex, ey;
    logic        rl;
    bit          typed;
    landing_t    want;
  } edge_row_t;

  logic clk, rst;
  logic psel, penable, pwrite;
  logic [4:0] paddr;
  logic [31:0] pwdata, prdata;
  logic pready;
  logic in_valid, in_ready;
  logic signed [31:0] start_x, start_y, end_x, end_y;
  logic is_real;
  logic out_valid, out_ready;
  logic [12:0] node_index;
  logic [3:0] landing_depth;
  logic [1:0] stop_reason;
  logic [15:0] real_total, mini_total;

  kd_block_edge_binning_core dut (.*);

  int signed box_x0, box_y0, box_x1, box_y1;
  int unsigned leaf_lim;
  int unsigned real_bin[SLOTS];
  int unsigned mini_bin[SLOTS];

  landing_t landing_q[$];
  edge_row_t typed_q[$];
  int errors, mismatches, edges_sent, results_seen, sat_hits;
  bit no_gaps;
  int rd_mode, rd_left;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #30ms;
    $display("Timeout waiting for results");
    $display("DONE: errors detected");
    $finish;
  end

  function automatic landing_t bin_edge(logic [31:0] sx, logic [31:0] sy, logic [31:0] ex,
                                        logic [31:0] ey, logic rl);
    longint ax, ay, bx, by, x0, y0, x1, y1, w, h, mid, lim;
    int unsigned node, depth, slot;
    bit along_x, p1, p2;
    landing_t r;
    ax = longint'(signed'(sx));
    ay = longint'(signed'(sy));
    bx = longint'(signed'(ex));
    by = longint'(signed'(ey));
    x0 = box_x0; y0 = box_y0; x1 = box_x1; y1 = box_y1;
    lim = leaf_lim;
    node = 1;
    depth = 0;
    forever begin
      slot = node % SLOTS;
      if (rl) begin
        if (real_bin[slot] < COUNT_TOP) real_bin[slot]++;
      end else begin
        if (mini_bin[slot] < COUNT_TOP) mini_bin[slot]++;
      end
      w = x1 - x0;
      h = y1 - y0;
      if (w <= lim && h <= lim) begin
        r.reason = STOP_LEAF;
        break;
      end
      along_x = (w >= h);
      mid = along_x ? (x0 + x1) / 2 : (y0 + y1) / 2;
      p1 = along_x ? (ax >= mid * 65536) : (ay >= mid * 65536);
      p2 = along_x ? (bx >= mid * 65536) : (by >= mid * 65536);
      if (p1 != p2) begin
        r.reason = STOP_CROSS;
        break;
      end
      if (depth >= DEPTH_LIMIT) begin
        r.reason = STOP_DEPTH;
        break;
      end
      if (along_x) begin
        if (p1) x0 = mid; else x1 = mid;
      end else begin
        if (p1) y0 = mid; else y1 = mid;
      end
      node = node * 2 + p1;
      depth++;
    end
    slot = node % SLOTS;
    r.node = node[12:0];
    r.depth = depth[3:0];
    r.real_cnt = real_bin[slot][15:0];
    r.mini_cnt = mini_bin[slot][15:0];
    return r;
  endfunction

  always @(posedge clk) begin
    landing_t e;
    edge_row_t t;
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (landing_q.size() == 0) begin
        errors++;
        $display("Unexpected result node=%0d", node_index);
      end else begin
        e = landing_q.pop_front();
        if (e.node != node_index || e.depth != landing_depth || e.reason != stop_reason ||
            e.real_cnt != real_total || e.mini_cnt != mini_total) begin
          errors++;
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch exp node=%0d d=%0d r=%0d rt=%0d mt=%0d got %0d %0d %0d %0d %0d",
                     e.node, e.depth, e.reason, e.real_cnt, e.mini_cnt, node_index,
                     landing_depth, stop_reason, real_total, mini_total);
        end
        if (real_total == 16'hFFFF || mini_total == 16'hFFFF) sat_hits++;
      end
    end
    if (!rst && in_valid && in_ready) begin
      t = typed_q.pop_front();
      e = bin_edge(start_x, start_y, end_x, end_y, is_real);
      landing_q.push_back(t.typed ? t.want : e);
    end
  end

  always @(posedge clk) begin
    if (rd_left == 0) begin
      rd_mode <= $urandom_range(0, 2);
      rd_left <= $urandom_range(20, 120);
    end else begin
      rd_left <= rd_left - 1;
    end
    case (rd_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= $urandom_range(0, 1);
      default: out_ready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  task automatic reg_write(logic [2:0] idx, logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_MIN_X: box_x0 = signed'(val[15:0]);
      REG_MIN_Y: box_y0 = signed'(val[15:0]);
      REG_MAX_X: box_x1 = signed'(val[15:0]);
      REG_MAX_Y: box_y1 = signed'(val[15:0]);
      default:   leaf_lim = val[15:0];
    endcase
  endtask

  task automatic set_box(int signed x0, int signed y0, int signed x1, int signed y1,
                         int unsigned lim);
    reg_write(REG_MIN_X, 32'(x0));
    reg_write(REG_MIN_Y, 32'(y0));
    reg_write(REG_MAX_X, 32'(x1));
    reg_write(REG_MAX_Y, 32'(y1));
    reg_write(REG_LEAF, lim);
  endtask

  task automatic drain();
    while (landing_q.size() != 0 || typed_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic send_edge(edge_row_t row);
    typed_q.push_back(row);
    @(posedge clk);
    in_valid <= 1'b1;
    start_x <= row.sx;
    start_y <= row.sy;
    end_x <= row.ex;
    end_y <= row.ey;
    is_real <= row.rl;
    do @(posedge clk); while (!(in_valid && in_ready));
    edges_sent++;
    in_valid <= 1'b0;
    if (!no_gaps && $urandom_range(0, 3) == 0) repeat ($urandom_range(0, 12)) @(posedge clk);
  endtask

  function automatic logic [31:0] coord_in(int signed lo, int signed hi);
    int signed a, b;
    a = (lo < hi) ? lo : hi;
    b = (lo < hi) ? hi : lo;
    return 32'((a + int'($urandom_range(0, b - a))) * 65536 + int'($urandom_range(0, 65535)));
  endfunction

  function automatic edge_row_t rand_edge();
    edge_row_t r;
    int sh;
    r.typed = 0;
    r.rl = $urandom_range(0, 1);
    if ($urandom_range(0, 4) == 0) begin
      r.sx = $urandom; r.sy = $urandom; r.ex = $urandom; r.ey = $urandom;
    end else begin
      sh = $urandom_range(0, 26);
      r.sx = coord_in(box_x0, box_x1);
      r.sy = coord_in(box_y0, box_y1);
      r.ex = r.sx + (($urandom >> (31 - sh)) - (32'h1 << sh) / 2);
      r.ey = r.sy + (($urandom >> (31 - sh)) - (32'h1 << sh) / 2);
    end
    return r;
  endfunction

  function automatic edge_row_t row(logic [31:0] sx, logic [31:0] sy, logic [31:0] ex,
                                    logic [31:0] ey, logic rl);
    edge_row_t r;
    r.sx = sx; r.sy = sy; r.ex = ex; r.ey = ey; r.rl = rl;
    r.typed = 0;
    return r;
  endfunction

  function automatic edge_row_t typed_row(edge_row_t r, int node, int depth, logic [1:0] why,
                                          int rt, int mt);
    r.typed = 1;
    r.want.node = node;
    r.want.depth = depth;
    r.want.reason = why;
    r.want.real_cnt = rt;
    r.want.mini_cnt = mt;
    return r;
  endfunction

  task automatic random_run(int n);
    repeat (n) send_edge(rand_edge());
  endtask

  initial begin
    edge_row_t dir_tab[$];
    int signed a, b;
    rst = 1;
    psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
    in_valid = 0; start_x = 0; start_y = 0; end_x = 0; end_y = 0; is_real = 0;
    out_ready = 0; rd_mode = 0; rd_left = 0; no_gaps = 0;
    errors = 0; mismatches = 0; edges_sent = 0; results_seen = 0; sat_hits = 0;
    box_x0 = -32768; box_y0 = -32768; box_x1 = 32767; box_y1 = 32767; leaf_lim = 256;
    foreach (real_bin[i]) begin
      real_bin[i] = 0;
      mini_bin[i] = 0;
    end
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    dir_tab.push_back(typed_row(row(-65536, 0, 65536, 0, 1), 1, 0, STOP_CROSS, 1, 0));
    dir_tab.push_back(typed_row(row(-65536, 0, 65536, 0, 0), 1, 0, STOP_CROSS, 1, 1));
    dir_tab.push_back(typed_row(row(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                                    32'h7FFF_FFFF, 0), 1, 0, STOP_CROSS, 1, 2));
    dir_tab.push_back(row(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1));
    dir_tab.push_back(row(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0));
    dir_tab.push_back(row(0, 0, 0, 0, 1));
    dir_tab.push_back(row(32'hFFFF_FFFF, 0, 0, 32'hFFFF_FFFF, 1));
    dir_tab.push_back(row(32'h1000_0000, 32'h1000_0000, 32'h1000_0100, 32'h1000_0000, 0));
    dir_tab.push_back(row(32'hF000_0000, 32'h2000_0000, 32'hF000_8000, 32'h2001_0000, 1));
    dir_tab.push_back(row(32'h0000_FFFF, 32'h0000_FFFF, 32'h0001_0000, 32'h0000_FFFF, 1));
    foreach (dir_tab[i]) send_edge(dir_tab[i]);
    random_run(90);
    drain();

    set_box(-32768, -32768, 32767, 32767, 1);
    send_edge(row(32'h0123_4567, 32'h7654_3210, 32'h0123_4568, 32'h7654_3211, 1));
    random_run(90);
    drain();

    set_box(100, -50, -100, 50, 0);
    send_edge(row(0, 0, 0, 32'h0010_0000, 1));
    send_edge(row(0, 32'hFFF0_0000, 0, 32'hFFF0_0001, 0));
    random_run(40);
    drain();

    set_box(0, 0, 1, 0, 0);
    send_edge(row(0, 0, 0, 0, 1));
    send_edge(row(32'hFFFF_FFFF, 0, 32'hFFFF_FFFF, 0, 0));
    send_edge(row(32'hFFFF_FFFF, 0, 0, 0, 1));
    random_run(20);
    drain();

    repeat (5) begin
      a = int'($urandom_range(0, 65535)) - 32768;
      b = int'($urandom_range(0, 65535)) - 32768;
      set_box(a, b, a + int'($urandom_range(0, 32767 - a)), b + int'($urandom_range(0, 32767 - b)),
              ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 64));
      random_run(50);
      drain();
    end

    $display("Sent %0d edges, checked %0d results over 9 root box settings", edges_sent,
             results_seen);
    $display("Counter saturation seen on %0d results", sat_hits);
    if (errors == 0 && landing_q.size() == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end
endmodule

// File: filelist.f
+incdir+hdl
hdl/kdbin_pkg.sv
hdl/kdbin_cell.sv
hdl/kd_block_edge_binning_core.sv
tb/sv/tb_kd_block_edge_binning_core.sv
